[sv/ahso_pkg.sv]
// Shared types, register codes and fixed-point constants for the harmonic sine oscillator.
// Holds the quarter-wave sine function that builds the ROM contents at elaboration.
// No dependencies.
package ahso_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 16;
   localparam int COUNT_W     = 4;
   localparam int STEP_W      = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int QSINE_W     = 15;
   localparam int FRAC_SHIFT  = 30;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [GAIN_W-1:0]          gain_type;
   typedef logic [COUNT_W-1:0]         count_type;

   localparam logic [CSR_INDEX_W-1:0] REG_HARMONIC_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HARMONIC_GAIN  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OUTPUT_GAIN    = 2'd2;

   localparam count_type RST_HARMONIC_COUNT = 4'd0;
   localparam gain_type  RST_HARMONIC_GAIN  = 16'd8192;
   localparam gain_type  RST_OUTPUT_GAIN    = 16'd9830;

   localparam logic [GAIN_W:0]     UNITY_GAIN = 17'd32768;
   localparam logic [SAMPLE_W-2:0] SAMPLE_MAX = 15'd32767;

   localparam logic [63:0] POLY_C1 = 64'd1686629713;
   localparam logic [63:0] POLY_C3 = 64'd693598668;
   localparam logic [63:0] POLY_C5 = 64'd85569306;
   localparam logic [63:0] POLY_C7 = 64'd5026995;
   localparam logic [63:0] POLY_C9 = 64'd172273;

   // Quarter-wave value 0..32767 for offset u in 0..2^qbits, odd polynomial in Q30.
   function automatic logic [QSINE_W-1:0] quarter_sine(input int unsigned qbits,
                                                       input logic [63:0] u);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] p;
      logic [63:0] v;
      x  = u << (FRAC_SHIFT - qbits);
      x2 = (x * x) >> FRAC_SHIFT;
      p  = POLY_C9;
      p  = POLY_C7 - ((x2 * p) >> FRAC_SHIFT);
      p  = POLY_C5 - ((x2 * p) >> FRAC_SHIFT);
      p  = POLY_C3 - ((x2 * p) >> FRAC_SHIFT);
      p  = POLY_C1 - ((x2 * p) >> FRAC_SHIFT);
      v  = (x * p) >> FRAC_SHIFT;
      v  = (v * 64'd32767 + (64'd1 << 29)) >> FRAC_SHIFT;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[QSINE_W-1:0];
   endfunction

endpackage

[sv/ahso_sine_rom.sv]
// Sine ROM with registered read: quarter-wave table folded over four quadrants.
// Depends on ahso_pkg for the sample type and the quarter-wave function.
module ahso_sine_rom import ahso_pkg::*; #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [SINE_TABLE_BITS-1:0] rd_index,
   output sample_type                 sine_ff
);

   localparam int QB    = SINE_TABLE_BITS - 2;
   localparam int QSIZE = 1 << QB;

   logic [QSINE_W-1:0] qtab [0:QSIZE];

   for (genvar u = 0; u <= QSIZE; u++) begin : g_qtab
      localparam logic [QSINE_W-1:0] QVAL = quarter_sine(QB, 64'(u));
      assign qtab[u] = QVAL;
   end

   logic [1:0]         quad;
   logic [QB-1:0]      offset;
   logic [QB:0]        qaddr;
   logic [QSINE_W-1:0] mag;
   sample_type         sine_in;

   always_comb begin
      quad   = rd_index[SINE_TABLE_BITS-1 -: 2];
      offset = rd_index[QB-1:0];
      // odd quadrants run the quarter wave backward
      if (quad[0]) begin
         qaddr = (QB+1)'(QSIZE) - {1'b0, offset};
      end else begin
         qaddr = {1'b0, offset};
      end
      mag = qtab[qaddr];
      if (quad[1]) begin
         sine_in = -$signed({1'b0, mag});
      end else begin
         sine_in = $signed({1'b0, mag});
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         sine_ff <= sine_in;
      end
   end

endmodule

[sv/ahso_mul.sv]
// Shared signed-by-unsigned multiplier with a registered product.
// No package dependencies.
module ahso_mul #(
   parameter int A_W = 43,
   parameter int B_W = 21
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [A_W-1:0]    a,
   input  logic        [B_W-1:0]    b,
   output logic signed [A_W+B_W:0]  p_ff
);

   logic signed [A_W+B_W:0] p_in;

   always_comb begin
      p_in = (A_W+B_W+1)'(a) * (A_W+B_W+1)'($signed({1'b0, b}));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

endmodule

[sv/additive_harmonic_sine_oscillator.sv]
// Additive harmonic sine oscillator: phase accumulator, sine ROM and one shared multiplier.
// Each sample works through the harmonics used, from the fundamental up: a ROM read, a multiply
// and an accumulate per harmonic on the shared multiplier, then a scale and a saturate step.
// Saturate waits for a free output; a request is taken only in idle, one sample at a time.
// Reset (synchronous): phase zero, registers to their defaults, no result pending.
// Depends on ahso_pkg, ahso_sine_rom and ahso_mul.
module additive_harmonic_sine_oscillator import ahso_pkg::*; #(
   parameter int MAX_HARMONICS   = 15,
   parameter int SINE_TABLE_BITS = 10,
   parameter int PHASE_BITS      = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [STEP_W-1:0]      req_phase_step,
   input  logic                   req_note_start,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sample_type             rsp_sample,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]      csr_wdata
);

   localparam int KW     = $clog2(MAX_HARMONICS + 2);
   localparam int WGT_W  = GAIN_W + KW;
   localparam int ACC_W  = SAMPLE_W + 1 + WGT_W + KW;
   localparam int PROD_W = ACC_W + WGT_W + 1;
   localparam int HI_W   = PROD_W - FRAC_SHIFT;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROM   = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_ACC   = 3'd3;
   localparam logic [2:0] S_SCALE = 3'd4;
   localparam logic [2:0] S_SAT   = 3'd5;

   logic [2:0]              state_ff, state_in;
   count_type               harmonic_count_ff, harmonic_count_in;
   gain_type                harmonic_gain_ff, harmonic_gain_in;
   gain_type                output_gain_ff, output_gain_in;
   logic [PHASE_BITS-1:0]   phase_accum_ff, phase_accum_in;
   logic [PHASE_BITS-1:0]   base_ff, base_in;
   logic [PHASE_BITS-1:0]   hphase_ff, hphase_in;
   logic [KW-1:0]           k_ff, k_in;
   logic [KW-1:0]           count_ff, count_in;
   logic [WGT_W-1:0]        wsum_ff, wsum_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    neg_ff, neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   sample_type              rsp_sample_ff, rsp_sample_in;

   logic                    req_xfer;
   logic                    csr_xfer;
   logic                    rom_en;
   sample_type              rom_sine;
   logic                    mul_en;
   logic signed [ACC_W-1:0] mul_a;
   logic [WGT_W-1:0]        mul_b;
   logic signed [PROD_W-1:0] prod;
   logic [PHASE_BITS-1:0]   phase_now;
   logic [HI_W-1:0]         prod_hi;
   logic [SAMPLE_W-2:0]     mag_sat;
   logic                    load_rsp;

   ahso_sine_rom #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_en   (rom_en),
      .rd_index(hphase_ff[PHASE_BITS-1 -: SINE_TABLE_BITS]),
      .sine_ff (rom_sine)
   );

   ahso_mul #(
      .A_W(ACC_W),
      .B_W(WGT_W)
   ) u_mul (
      .clock(clock),
      .en   (mul_en),
      .a    (mul_a),
      .b    (mul_b),
      .p_ff (prod)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign req_xfer   = req_valid && req_ready;
   assign csr_xfer   = csr_valid && csr_ready;

   always_comb begin
      state_in          = state_ff;
      harmonic_count_in = harmonic_count_ff;
      harmonic_gain_in  = harmonic_gain_ff;
      output_gain_in    = output_gain_ff;
      phase_accum_in    = phase_accum_ff;
      base_in           = base_ff;
      hphase_in         = hphase_ff;
      k_in              = k_ff;
      count_in          = count_ff;
      wsum_in           = wsum_ff;
      acc_in            = acc_ff;
      neg_in            = neg_ff;
      rsp_sample_in     = rsp_sample_ff;
      rom_en            = 1'b0;
      mul_en            = 1'b0;
      load_rsp          = 1'b0;
      mul_a             = ACC_W'(rom_sine);
      mul_b             = (k_ff == '0) ? WGT_W'(UNITY_GAIN) : wsum_ff;
      phase_now         = req_note_start ? '0 : phase_accum_ff;
      prod_hi           = prod[PROD_W-1:FRAC_SHIFT];
      if (prod_hi > HI_W'(SAMPLE_MAX)) begin
         mag_sat = SAMPLE_MAX;
      end else begin
         mag_sat = prod_hi[SAMPLE_W-2:0];
      end

      if (csr_xfer) begin
         case (csr_index)
            REG_HARMONIC_COUNT: harmonic_count_in = csr_wdata[COUNT_W-1:0];
            REG_HARMONIC_GAIN:  harmonic_gain_in  = csr_wdata;
            REG_OUTPUT_GAIN:    output_gain_in    = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               base_in        = phase_now;
               hphase_in      = phase_now;
               phase_accum_in = phase_now + PHASE_BITS'(req_phase_step);
               k_in           = '0;
               wsum_in        = WGT_W'(harmonic_gain_ff);
               acc_in         = '0;
               if (32'(harmonic_count_ff) > MAX_HARMONICS) begin
                  count_in = KW'(MAX_HARMONICS);
               end else begin
                  count_in = KW'(harmonic_count_ff);
               end
               state_in = S_ROM;
            end
         end
         S_ROM: begin
            rom_en   = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            mul_en   = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = acc_ff + ACC_W'(prod);
            if (k_ff == count_ff) begin
               state_in = S_SCALE;
            end else begin
               // advance to the next harmonic: phase times k, weight k times gain
               hphase_in = hphase_ff + base_ff;
               wsum_in   = wsum_ff + WGT_W'(harmonic_gain_ff);
               k_in      = k_ff + 1'b1;
               state_in  = S_ROM;
            end
         end
         S_SCALE: begin
            mul_en = 1'b1;
            neg_in = acc_ff[ACC_W-1];
            mul_a  = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
            mul_b  = WGT_W'(output_gain_ff);
            state_in = S_SAT;
         end
         S_SAT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               if (neg_ff) begin
                  rsp_sample_in = -$signed({1'b0, mag_sat});
               end else begin
                  rsp_sample_in = $signed({1'b0, mag_sat});
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         harmonic_count_ff <= RST_HARMONIC_COUNT;
         harmonic_gain_ff  <= RST_HARMONIC_GAIN;
         output_gain_ff    <= RST_OUTPUT_GAIN;
         phase_accum_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         harmonic_count_ff <= harmonic_count_in;
         harmonic_gain_ff  <= harmonic_gain_in;
         output_gain_ff    <= output_gain_in;
         phase_accum_ff    <= phase_accum_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      hphase_ff     <= hphase_in;
      k_ff          <= k_in;
      count_ff      <= count_in;
      wsum_ff       <= wsum_in;
      acc_ff        <= acc_in;
      neg_ff        <= neg_in;
      rsp_sample_ff <= rsp_sample_in;
   end

endmodule

[bench/additive_harmonic_sine_oscillator_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for additive_harmonic_sine_oscillator: predicts every PCM sample from
// its own sine table and harmonic sum, and drives the sample, result and register channels.
// Depends on ahso_pkg and the oscillator RTL.
module additive_harmonic_sine_oscillator_tb;
   import ahso_pkg::*;

   localparam int TABLE_BITS      = 10;
   localparam int QTR_BITS        = TABLE_BITS - 2;
   localparam int PHASE_W         = 32;
   localparam int HARMONIC_LIMIT  = 15;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int TAIL_CYCLES     = 60;
   localparam int PHASE_COUNT     = 12;
   localparam int ITEMS_PER_PHASE = 50;
   localparam logic [63:0] QTR_SIZE = 64'd1 << QTR_BITS;
   localparam longint ACC_CLAMP = longint'(1) << 47;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [STEP_W-1:0]      req_phase_step = '0;
   logic                   req_note_start = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   sample_type             rsp_sample;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [GAIN_W-1:0]      csr_wdata = '0;

   int unsigned send_idle = 0;
   int unsigned recv_idle = 0;
   int          idle_cycles = 0;

   class oscillator_scoreboard;
      count_type   harmonics;
      gain_type    harm_gain;
      gain_type    out_gain;
      logic [31:0] phase;
      sample_type  expected_samples[$];
      int          failures;

      function new();
         harmonics = RST_HARMONIC_COUNT;
         harm_gain = RST_HARMONIC_GAIN;
         out_gain  = RST_OUTPUT_GAIN;
         phase     = '0;
         failures  = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [GAIN_W-1:0] data);
         case (idx)
            REG_HARMONIC_COUNT: harmonics = data[COUNT_W-1:0];
            REG_HARMONIC_GAIN:  harm_gain = data;
            REG_OUTPUT_GAIN:    out_gain  = data;
            default: ;
         endcase
      endfunction

      // Quarter-wave amplitude 0..32767, odd Q30 polynomial by Horner's rule.
      function logic [63:0] quarter_wave(logic [63:0] u);
         logic [63:0] x;
         logic [63:0] x2;
         logic [63:0] p;
         logic [63:0] v;
         x  = u << (FRAC_SHIFT - QTR_BITS);
         x2 = (x * x) >> FRAC_SHIFT;
         p  = POLY_C9;
         p  = POLY_C7 - ((x2 * p) >> FRAC_SHIFT);
         p  = POLY_C5 - ((x2 * p) >> FRAC_SHIFT);
         p  = POLY_C3 - ((x2 * p) >> FRAC_SHIFT);
         p  = POLY_C1 - ((x2 * p) >> FRAC_SHIFT);
         v  = (x * p) >> FRAC_SHIFT;
         v  = (v * 64'd32767 + (64'd1 << 29)) >> FRAC_SHIFT;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         return v;
      endfunction

      function longint wave_at(logic [PHASE_W-1:0] ph);
         logic [TABLE_BITS-1:0] idx;
         logic [63:0]           v;
         idx = ph[PHASE_W-1 -: TABLE_BITS];
         // mirror the offset in odd quadrants, negate in the second half turn
         if (idx[TABLE_BITS-2]) begin
            v = quarter_wave(QTR_SIZE - 64'(idx[QTR_BITS-1:0]));
         end else begin
            v = quarter_wave(64'(idx[QTR_BITS-1:0]));
         end
         return idx[TABLE_BITS-1] ? -longint'(v) : longint'(v);
      endfunction

      function sample_type predict(logic [PHASE_W-1:0] ph);
         longint            acc;
         logic [63:0]       mag;
         logic [PHASE_W-1:0] hphase;
         int                top;
         bit                neg;
         top = (harmonics > HARMONIC_LIMIT) ? HARMONIC_LIMIT : int'(harmonics);
         acc = wave_at(ph) * longint'(UNITY_GAIN);
         for (int k = 2; k <= top + 1; k++) begin
            hphase = ph * PHASE_W'(k);
            acc += wave_at(hphase) * longint'(k) * longint'(harm_gain);
         end
         if (acc > ACC_CLAMP) begin
            acc = ACC_CLAMP;
         end else if (acc < -ACC_CLAMP) begin
            acc = -ACC_CLAMP;
         end
         neg = acc < 0;
         mag = neg ? 64'(-acc) : 64'(acc);
         mag = (mag * 64'(out_gain)) >> FRAC_SHIFT;
         if (mag > 64'(SAMPLE_MAX)) begin
            mag = 64'(SAMPLE_MAX);
         end
         if (neg) begin
            mag = -mag;
         end
         return mag[SAMPLE_W-1:0];
      endfunction

      // One accepted sample tick: form the sample from the current phase, then advance.
      function void note_tick(logic [STEP_W-1:0] step, logic start);
         if (start) begin
            phase = '0;
         end
         expected_samples.push_back(predict(phase));
         phase = phase + step;
      endfunction

      function void check_sample(sample_type actual);
         sample_type want;
         if (expected_samples.size() == 0) begin
            $error("unexpected sample transfer: actual %0d", actual);
            failures++;
         end else begin
            want = expected_samples.pop_front();
            if (actual !== want) begin
               $error("mismatch on sample: expected %0d actual %0d", want, actual);
               failures++;
            end
         end
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction
   endclass

   oscillator_scoreboard sb;

   additive_harmonic_sine_oscillator #(
      .MAX_HARMONICS  (HARMONIC_LIMIT),
      .SINE_TABLE_BITS(TABLE_BITS),
      .PHASE_BITS     (PHASE_W)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_phase_step(req_phase_step),
      .req_note_start(req_note_start),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sample    (rsp_sample),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #2 clock = ~clock;

   // Sample sink: check each transfer, then stall at random for the next edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sb.check_sample(rsp_sample);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                   (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("additive_harmonic_sine_oscillator test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input logic [STEP_W-1:0] step, input logic start);
      if (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid      <= 1'b1;
      req_phase_step <= step;
      req_note_start <= start;
      do @(posedge clock); while (!req_ready);
      sb.note_tick(step, start);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [GAIN_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   task automatic program_regs(input logic [GAIN_W-1:0] count_data,
                               input logic [GAIN_W-1:0] hgain,
                               input logic [GAIN_W-1:0] ogain,
                               input bit poke_unused);
      csr_write(REG_HARMONIC_COUNT, count_data);
      csr_write(REG_HARMONIC_GAIN, hgain);
      csr_write(REG_OUTPUT_GAIN, ogain);
      if (poke_unused) begin
         csr_write(REG_UNUSED, GAIN_W'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   // Drop valid and hold until every sample has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(7))
         0: return '0;
         1: return UNITY_GAIN[GAIN_W-1:0];
         2: return '1;
         3: return GAIN_W'($urandom_range(32769, 65535));
         default: return GAIN_W'($urandom_range(0, 32768));
      endcase
   endfunction

   initial begin
      int                 notes_left;
      logic [STEP_W-1:0]  note_step;
      logic [GAIN_W-1:0]  count_data;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Defaults out of reset; quarter-turn steps walk all four quadrants and wrap.
      send_item(32'h0000_0000, 1'b1);
      repeat (4) send_item(32'h4000_0000, 1'b0);
      drain();

      // Every harmonic at gains above one: saturates both ways.
      program_regs(16'h000F, 16'hFFFF, 16'hFFFF, 1'b0);
      send_item(32'h0000_0001, 1'b1);
      send_item(32'hFFFF_FFFF, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h1234_5678, 1'b0);
      drain();

      // Unity gains, upper count bits set, plus a write to the unused index.
      program_regs(16'hFFFF, UNITY_GAIN[GAIN_W-1:0], UNITY_GAIN[GAIN_W-1:0], 1'b1);
      send_item(32'h0555_5555, 1'b1);
      send_item(32'hAAAA_AAAA, 1'b0);
      send_item(32'h0020_0000, 1'b1);
      send_item(32'h7FFF_FFFF, 1'b0);
      drain();

      // Zero gains and no harmonics.
      program_regs(16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_item(32'h0100_0000, 1'b1);
      send_item(32'h0100_0000, 1'b0);
      drain();

      program_regs(16'h0000, 16'h0000, UNITY_GAIN[GAIN_W-1:0], 1'b0);
      send_item(32'h2000_0000, 1'b1);
      send_item(32'h2000_0000, 1'b0);
      send_item(32'h2000_0000, 1'b0);
      drain();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p < PHASE_COUNT / 3) begin
            send_idle = 23;
            recv_idle = 87;
         end else if (p < 2 * PHASE_COUNT / 3) begin
            send_idle = 87;
            recv_idle = 23;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         case (p % 3)
            0: count_data = {12'($urandom), 4'hF};
            1: count_data = {12'($urandom), 4'h0};
            default: count_data = GAIN_W'($urandom);
         endcase
         program_regs(count_data, pick_gain(), pick_gain(), 1'($urandom));
         notes_left = 0;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if ($urandom_range(99) < 15) begin
               send_item(STEP_W'($urandom), 1'($urandom));
            end else begin
               // held notes: restart the phase, then run a steady pitch
               if (notes_left == 0) begin
                  note_step  = STEP_W'($urandom_range(32'd2_000_000, 32'd900_000_000));
                  notes_left = $urandom_range(5, 40);
                  send_item(note_step, 1'b1);
               end else begin
                  send_item(note_step, 1'b0);
               end
               notes_left--;
            end
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d samples never returned", sb.pending());
         sb.failures++;
      end
      if (sb.failures == 0) begin
         $display("additive_harmonic_sine_oscillator test passed");
      end else begin
         $display("additive_harmonic_sine_oscillator test failed");
      end
      $finish;
   end

endmodule
